// ===== hdl/ort_pkg.sv =====
// Shared types and constants for the overwriting ring queue.
package ort_pkg;

    // Queue geometry; the capacity must be a power of two so that indices wrap by truncation.
    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = 4;
    localparam int POS_W      = 3;

    // Command codes carried by each input beat.
    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_READ = 2'd2,
        CMD_RSVD = 2'd3
    } cmd_t;

    // Input beat payload.
    typedef struct packed {
        cmd_t                  cmd;
        logic [DATA_WIDTH-1:0] value;
        logic [POS_W-1:0]      position;
    } in_beat_t;

    // Result beat payload.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic [CNT_W-1:0]      fill_count;
        logic                  was_empty;
        logic                  overwrote_oldest;
        logic                  bad_position;
    } out_beat_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic load_read;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
    } sts_t;

endpackage

// ===== hdl/ort_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/ort_ctrl.sv =====
// Controller state machine for the overwriting ring queue.
module ort_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  ort_pkg::sts_t sts,
    output ort_pkg::ctl_t ctl
);

    import ort_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;

    // A beat can be taken when nothing is pending or the pending result leaves now.
    assign take = in_valid && in_ready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = sts.is_read ? ST_READ : ST_SEND;
                end
            end
            ST_READ:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_ready)
                begin
                    if (take)
                    begin
                        state_next = sts.is_read ? ST_READ : ST_SEND;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        ctl.load_read = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_READ:
            begin
                ctl.load_read = 1'b1;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        ctl.take = in_valid && in_ready;
    end

    // No beat is taken while a read waits on the memory.
    a_no_take_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !in_ready)
        else $error("input taken during memory read");

    // A taken read always goes through the memory wait state.
    a_read_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (take && sts.is_read) |=> (state_reg == ST_READ))
        else $error("read did not wait for memory data");

    // The memory wait state always leads to a result.
    a_read_sends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_SEND))
        else $error("read result not presented");

endmodule

// ===== hdl/ort_datapath.sv =====
// Datapath of the overwriting ring queue: pointers, slot memory and result register.
module ort_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ort_pkg::in_beat_t in_data,
    input  ort_pkg::ctl_t     ctl,
    output ort_pkg::sts_t     sts,
    output ort_pkg::out_beat_t out_data
);

    import ort_pkg::*;

    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    logic [PTR_W-1:0]      head_reg;
    logic [PTR_W-1:0]      head_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  rd_ok_reg;
    logic                  rd_ok_next;
    out_beat_t             res_reg;
    out_beat_t             res_next;
    logic                  we;
    logic                  re;
    logic [PTR_W-1:0]      waddr;
    logic [PTR_W-1:0]      raddr;
    logic [DATA_WIDTH-1:0] rdata;

    assign sts.is_read = (in_data.cmd == CMD_READ);

    // Slot addresses: back of the queue for push, offset from the front for read.
    assign waddr = head_reg + count_reg[PTR_W-1:0];
    assign raddr = head_reg + in_data.position[PTR_W-1:0];

    // Command decode and pointer update for the beat being taken.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        rd_ok_next = rd_ok_reg;
        we         = 1'b0;
        re         = 1'b0;
        res_next   = res_reg;
        if (ctl.take)
        begin
            res_next = '0;
            unique case (in_data.cmd)
                CMD_PUSH:
                begin
                    we = 1'b1;
                    if (count_reg == FULL)
                    begin
                        head_next                 = head_reg + PTR_W'(1);
                        res_next.overwrote_oldest = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP:
                begin
                    if (count_reg == '0)
                    begin
                        res_next.was_empty = 1'b1;
                    end
                    else
                    begin
                        head_next  = head_reg + PTR_W'(1);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_READ:
                begin
                    re         = 1'b1;
                    rd_ok_next = ({1'b0, in_data.position} < count_reg);
                end
                CMD_RSVD:
                begin
                    res_next = '0;
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
            res_next.fill_count = count_next;
        end
        else if (ctl.load_read)
        begin
            // Memory data arrives from the registered read port in the cycle after the read was issued.
            res_next.read_data        = rd_ok_reg ? rdata : '0;
            res_next.fill_count       = count_reg;
            res_next.was_empty        = 1'b0;
            res_next.overwrote_oldest = 1'b0;
            res_next.bad_position     = !rd_ok_reg;
        end
    end

    // Pointer and count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Result register and pending read status.
    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        rd_ok_reg <= rd_ok_next;
    end

    assign out_data = res_reg;

    // Slot storage.
    ort_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (in_data.value),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("fill count above capacity");

    // An overwriting push leaves the queue full.
    a_overwrite_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.take && (in_data.cmd == CMD_PUSH) && (count_reg == FULL))
            |=> (count_reg == FULL) && res_reg.overwrote_oldest)
        else $error("overwrite did not keep queue full");

    // A read outside the held entries reports zero data and the flag.
    a_bad_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load_read && !rd_ok_reg)
            |=> (res_reg.read_data == '0) && res_reg.bad_position)
        else $error("out-of-range read returned data");

endmodule

// ===== hdl/overwriting_ring_queue.sv =====
// Top level of the overwriting ring queue.
//
// The queue holds up to eight 32-bit words. Each input beat on the in channel
// carries a command (push, pop, or read at an offset from the oldest entry)
// and every command gives exactly one result beat on the out channel, with
// the data read, the fill count after the command and three status flags.
// A push into a full queue replaces the oldest word and flags this.
//
// Both channels use valid and ready. For push, pop and the reserved code the
// result is in the output register on the cycle after the beat is taken,
// and with the receiver ready such commands run at one per cycle. A read
// goes through the registered read port of the slot memory and a wait
// state, during which no new input beat is taken.
//
// While a result waits, the next input beat is taken in the same cycle that
// the result leaves; a receiver that stalls holds the input off. Reset clears
// the head pointer and the fill count at once; slot contents are not cleared
// and no word is ever read back before it was written.
module overwriting_ring_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ort_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ort_pkg::out_beat_t out_data
);

    import ort_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // Sequencing of beats.
    ort_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Storage, pointers and results.
    ort_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .ctl      (ctl),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule
